[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the modular ALU.
// Stand-alone header; the ALU top level, which checks its own logic, includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LMMA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the following cycle.
`define LMMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lmma_pkg.sv]
// Package of the lazy Montgomery modular ALU: widths, opcodes, sequencer states.
// No dependencies; every RTL module and interface imports it.
package lmma_pkg;

	localparam int LMMA_W     = 32;
	localparam int LMMA_NW    = 30;
	localparam int LMMA_CMD_W = 4;
	localparam int LMMA_AW    = 4;

	typedef enum logic [LMMA_CMD_W-1:0] {
		CMD_TO_MONT   = 4'd0,
		CMD_FROM_MONT = 4'd1,
		CMD_MUL       = 4'd2,
		CMD_SQ        = 4'd3,
		CMD_ADD       = 4'd4,
		CMD_SUB       = 4'd5,
		CMD_NEG       = 4'd6,
		CMD_INV       = 4'd7,
		CMD_DIV       = 4'd8,
		CMD_EQ        = 4'd9,
		CMD_IS_ZERO   = 4'd10
	} cmd_t;

	// Register index within the configuration space
	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_NEG_INV = 2'd1,
		REG_R2      = 2'd2,
		REG_R3      = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED_M,
		ST_RED_Q,
		ST_RED_ADD,
		ST_INV_START,
		ST_INV_RED,
		ST_EUC_TEST,
		ST_EUC_DIV,
		ST_EUC_MUL,
		ST_EUC_UPD,
		ST_INV_CHK,
		ST_FIN
	} state_t;

endpackage

[hw/rtl/lmma_if.sv]
// Valid/ready channel interfaces for requests and responses of the modular ALU.
// Depends on lmma_pkg for the field widths.
interface lmma_req_if import lmma_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LMMA_CMD_W-1:0] cmd;
	logic [LMMA_W-1:0]     operand_a;
	logic [LMMA_W-1:0]     operand_b;

	modport source (output valid, cmd, operand_a, operand_b, input ready);
	modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface lmma_rsp_if import lmma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LMMA_W-1:0] value;
	logic              flag;
	logic              error;

	modport source (output valid, value, flag, error, input ready);
	modport sink   (input valid, value, flag, error, output ready);
endinterface

[hw/rtl/lmma_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lmma_pkg; used by the inverse sequence of the modular ALU.
module lmma_div import lmma_pkg::*; #(
	parameter int DW = LMMA_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(DW);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	// Trial subtraction of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[hw/rtl/lazy_montgomery_modular_alu.sv]
// Add/sub/neg/eq/is_zero and unused opcodes go from accept straight to the result state;
// Montgomery multiply-type ops run a product and a REDC on one shared 32x32 multiplier,
// used twice per REDC. Inverse: a reduction on the bit-serial divider if needed, then a
// divide, multiply and update per Euclid step, and a multiply by R3; divide adds a multiply
// by operand a. One transaction at a time; a stalled result holds the input.
// Reset (arst_n, async, active low) idles the sequencer and restores register defaults.
`include "assert_macros.svh"

module lazy_montgomery_modular_alu import lmma_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lmma_req_if.sink           req,
	lmma_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [LMMA_AW-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int W  = LMMA_W;
	localparam int PW = 2 * LMMA_W;

	// Configuration registers
	logic [LMMA_NW-1:0] modulus_q;
	logic [W-1:0]       neg_inv_q, r2_q, r3_q;
	reg_idx_t           reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= LMMA_NW'(1);
			neg_inv_q <= '1;
			r2_q      <= W'(1);
			r3_q      <= W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MODULUS: modulus_q <= pwdata[LMMA_NW-1:0];
				REG_NEG_INV: neg_inv_q <= pwdata;
				REG_R2:      r2_q      <= pwdata;
				REG_R3:      r3_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODULUS: prdata = {{(32-LMMA_NW){1'b0}}, modulus_q};
			REG_NEG_INV: prdata = neg_inv_q;
			REG_R2:      prdata = r2_q;
			REG_R3:      prdata = r3_q;
			default:     prdata = '0;
		endcase
	end

	logic [W-1:0] n, n2;
	assign n  = W'(modulus_q);
	assign n2 = W'({modulus_q, 1'b0});

	// Sequencer and datapath registers
	state_t       state_q, state_d;
	cmd_t         cmd_q;
	logic [W-1:0] opa_q, opb_q, ma_q, mb_q, res_q;
	logic [PW-1:0] prod_q, p_q;
	logic [W-1:0] ex_q, ey_q, ea_q, eb_q;
	logic         err_q, second_q;
	logic         out_valid_q, out_flag_q, out_err_q;
	logic [W-1:0] out_val_q;

	// Divider
	logic         div_start, div_done;
	logic [W-1:0] div_dvd, div_dvs, div_quot, div_rem;

	lmma_div #(.DW(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Shared multiplier operand selection
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] mul_p, red_sum;

	always_comb begin
		unique case (state_q)
			ST_RED_M:   begin mul_a = prod_q[W-1:0]; mul_b = neg_inv_q; end
			ST_RED_Q:   begin mul_a = prod_q[W-1:0]; mul_b = n;         end
			ST_EUC_MUL: begin mul_a = div_quot;      mul_b = ea_q;      end
			default:    begin mul_a = ma_q;          mul_b = mb_q;      end
		endcase
	end

	assign mul_p   = PW'(mul_a) * PW'(mul_b);
	assign red_sum = prod_q + p_q;

	logic accept, out_free, reduce_in;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign reduce_in = (n != '0) && (ex_q >= n);

	// Next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = ey_q;
		div_dvs   = ex_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.cmd))
						CMD_TO_MONT, CMD_FROM_MONT, CMD_MUL, CMD_SQ: state_d = ST_MUL;
						CMD_INV, CMD_DIV: state_d = ST_INV_START;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_MUL:     state_d = ST_RED_M;
			ST_RED_M:   state_d = ST_RED_Q;
			ST_RED_Q:   state_d = ST_RED_ADD;
			ST_RED_ADD: state_d = (cmd_q == CMD_DIV && !second_q) ? ST_MUL : ST_FIN;
			ST_INV_START: begin
				if (reduce_in) begin
					div_start = 1'b1;
					div_dvd   = ex_q;
					div_dvs   = n;
					state_d   = ST_INV_RED;
				end else begin
					state_d = ST_EUC_TEST;
				end
			end
			ST_INV_RED: if (div_done) state_d = ST_EUC_TEST;
			ST_EUC_TEST: begin
				if (ex_q == '0) begin
					state_d = ST_INV_CHK;
				end else begin
					div_start = 1'b1;
					state_d   = ST_EUC_DIV;
				end
			end
			ST_EUC_DIV: if (div_done) state_d = ST_EUC_MUL;
			ST_EUC_MUL: state_d = ST_EUC_UPD;
			ST_EUC_UPD: state_d = ST_EUC_TEST;
			ST_INV_CHK: state_d = (ey_q != W'(1)) ? ST_FIN : ST_MUL;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q    <= cmd_t'(req.cmd);
					opa_q    <= req.operand_a;
					opb_q    <= req.operand_b;
					second_q <= 1'b0;
					err_q    <= 1'b0;
					ma_q     <= req.operand_a;
					ex_q     <= (cmd_t'(req.cmd) == CMD_DIV) ? req.operand_b : req.operand_a;
					unique case (cmd_t'(req.cmd))
						CMD_TO_MONT:   mb_q <= r2_q;
						CMD_FROM_MONT: mb_q <= W'(1);
						CMD_SQ:        mb_q <= req.operand_a;
						default:       mb_q <= req.operand_b;
					endcase
				end
			end
			ST_MUL:   prod_q <= mul_p;
			ST_RED_M: begin
				p_q    <= prod_q;
				prod_q <= mul_p;
			end
			ST_RED_Q:   prod_q <= mul_p;
			ST_RED_ADD: begin
				res_q <= red_sum[PW-1:W];
				if (cmd_q == CMD_DIV && !second_q) begin
					second_q <= 1'b1;
					ma_q     <= opa_q;
					mb_q     <= red_sum[PW-1:W];
				end
			end
			ST_INV_START: begin
				ey_q <= n;
				ea_q <= W'(1);
				eb_q <= '0;
			end
			ST_INV_RED: if (div_done) ex_q <= div_rem;
			ST_EUC_MUL: prod_q <= mul_p;
			ST_EUC_UPD: begin
				// Remainder becomes the new x, the old x the new y; cofactors update and swap
				ex_q <= div_rem;
				ey_q <= ex_q;
				ea_q <= eb_q - prod_q[W-1:0];
				eb_q <= ea_q;
			end
			ST_INV_CHK: begin
				err_q <= (ey_q != W'(1));
				ma_q  <= eb_q + n;
				mb_q  <= r3_q;
			end
			default: ;
		endcase
	end

	// Final result formation per opcode
	logic [W-1:0] fin_val, s_add, s_sub;
	logic         fin_flag;

	assign s_add = opa_q + opb_q;
	assign s_sub = opa_q - opb_q;

	always_comb begin
		fin_val  = '0;
		fin_flag = 1'b0;
		unique case (cmd_q)
			CMD_TO_MONT, CMD_MUL, CMD_SQ: fin_val = res_q;
			CMD_FROM_MONT: fin_val = (res_q >= n) ? res_q - n : res_q;
			CMD_ADD:       fin_val = (s_add < n2) ? s_add : s_add - n2;
			CMD_SUB:       fin_val = (s_sub <= opa_q) ? s_sub : s_sub + n2;
			CMD_NEG:       fin_val = n2 - opa_q;
			CMD_INV, CMD_DIV: fin_val = err_q ? '0 : res_q;
			CMD_EQ: fin_flag = !((s_sub != '0) && (opa_q + n - opb_q != '0) &&
				(opb_q + n - opa_q != '0));
			CMD_IS_ZERO: fin_flag = (opa_q == '0) || (opa_q == n);
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_val_q  <= fin_val;
			out_flag_q <= fin_flag;
			out_err_q  <= err_q && (cmd_q == CMD_INV || cmd_q == CMD_DIV);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = out_val_q;
	assign rsp.flag  = out_flag_q;
	assign rsp.error = out_err_q;

	`LMMA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE, "accepted transaction left sequencer idle")
	`LMMA_ASSERT(a_error_zero_value, clk, arst_n, !(rsp.valid && rsp.error) || (rsp.value == '0 && !rsp.flag), "error result carries nonzero payload")
	`LMMA_ASSERT_NEXT(a_fin_delivers, clk, arst_n, state_q == ST_FIN && out_free, rsp.valid, "finished transaction not presented")
	`LMMA_ASSERT(a_flag_zero_value, clk, arst_n, !(rsp.valid && rsp.flag) || rsp.value == '0, "comparison result carries a value")

endmodule

[bench/lazy_montgomery_modular_alu_tb.sv]
// Self-checking bench for the lazy Montgomery modular ALU: directed and random
// operations under several modulus settings, with random stalls on both channels.
// Depends on lmma_pkg and the lmma_req_if / lmma_rsp_if interfaces.
module lazy_montgomery_modular_alu_tb;
	import lmma_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] value;
		logic        flag;
		logic        error;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [LMMA_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lmma_req_if req ();
	lmma_rsp_if rsp ();

	lazy_montgomery_modular_alu dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Shadow copies of the configuration registers
	logic [29:0] sh_mod = 30'd1;
	logic [31:0] sh_ninv = 32'hFFFF_FFFF;
	logic [31:0] sh_r2 = 32'd1;
	logic [31:0] sh_r3 = 32'd1;

	alu_result_t pending_results[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned hold_cycles = 0;
	bit          monitor_on = 1'b0;

	initial begin
		req.valid = 1'b0;
		req.cmd = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;
	end

	// Montgomery arithmetic on the shadow registers
	function automatic logic [31:0] redc_fn(logic [63:0] t);
		logic [31:0] m;
		logic [63:0] p;
		logic [64:0] s;
		m = t[31:0] * sh_ninv;
		p = 64'(m) * 64'({2'b0, sh_mod});
		s = 65'(p) + 65'(t);
		return s[63:32];
	endfunction

	function automatic logic [31:0] mont_product(logic [31:0] x, logic [31:0] y);
		return redc_fn(64'(x) * 64'(y));
	endfunction

	function automatic logic [31:0] mont_inverse(logic [31:0] xin, output logic bad);
		logic [31:0] n, x, y, a, b, d, t;
		n = {2'b0, sh_mod};
		x = xin;
		y = n;
		a = 32'd1;
		b = 32'd0;
		bad = 1'b0;
		if (n != 0 && x >= n) x = x % n;
		while (x != 0) begin
			d = y / x;
			y = y - d * x;
			b = b - d * a;
			t = x; x = y; y = t;
			t = a; a = b; b = t;
		end
		if (y != 32'd1) begin
			bad = 1'b1;
			return 32'd0;
		end
		return mont_product(b + n, sh_r3);
	endfunction

	function automatic alu_result_t alu_predict(logic [3:0] op, logic [31:0] x, logic [31:0] y);
		alu_result_t r;
		logic [31:0] n, n2, s, inv;
		logic bad;
		n = {2'b0, sh_mod};
		n2 = n << 1;
		r = '0;
		bad = 1'b0;
		case (op)
			CMD_TO_MONT: r.value = mont_product(x, sh_r2);
			CMD_FROM_MONT: begin
				s = redc_fn(64'(x));
				r.value = (s >= n) ? s - n : s;
			end
			CMD_MUL: r.value = mont_product(x, y);
			CMD_SQ: r.value = mont_product(x, x);
			CMD_ADD: begin
				s = x + y;
				r.value = (s < n2) ? s : s - n2;
			end
			CMD_SUB: begin
				s = x - y;
				r.value = (s <= x) ? s : s + n2;
			end
			CMD_NEG: r.value = n2 - x;
			CMD_INV: r.value = mont_inverse(x, bad);
			CMD_DIV: begin
				inv = mont_inverse(y, bad);
				r.value = bad ? 32'd0 : mont_product(x, inv);
			end
			CMD_EQ: r.flag = !((x - y) != 0 && (x + n - y) != 0 && (y + n - x) != 0);
			CMD_IS_ZERO: r.flag = (x == 0 || x == n);
			default: ;
		endcase
		r.error = bad;
		return r;
	endfunction

	// Cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout at %0t", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response checking against the oldest expectation
	always @(posedge clk) begin
		alu_result_t got, want;
		if (monitor_on && rsp.valid && rsp.ready) begin
			got = '{rsp.value, rsp.flag, rsp.error};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transaction: got %h/%b/%b", $time,
					got.value, got.flag, got.error);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$display("%0t value mismatch: expected %h actual %h", $time,
						want.value, got.value);
					errors++;
				end
				if (got.flag !== want.flag) begin
					$display("%0t flag mismatch: expected %b actual %b", $time,
						want.flag, got.flag);
					errors++;
				end
				if (got.error !== want.error) begin
					$display("%0t error mismatch: expected %b actual %b", $time,
						want.error, got.error);
					errors++;
				end
			end
		end
	end

	// Response stall: random per transaction, or a long hold when requested
	initial begin
		int unsigned w;
		@(posedge arst_n);
		forever begin
			if (hold_cycles != 0) begin
				rsp.ready <= 1'b0;
				while (hold_cycles != 0) begin
					@(posedge clk);
					hold_cycles = hold_cycles - 1;
				end
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (w != 0) begin
				rsp.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp.valid && rsp.ready)) @(posedge clk);
		end
	end

	bit no_gaps = 1'b0;

	// Valid stays high after acceptance until the next gap or a drain
	task automatic send_op(logic [3:0] op, logic [31:0] x, logic [31:0] y);
		int unsigned w;
		w = no_gaps ? 0 : $urandom_range(0, 18);
		if (w != 0) begin
			req.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.operand_a <= x;
		req.operand_b <= y;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(alu_predict(op, x, y));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LMMA_AW'(idx) << 2;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODULUS: sh_mod = data[29:0];
			REG_NEG_INV: sh_ninv = data;
			REG_R2: sh_r2 = data;
			REG_R3: sh_r3 = data;
		endcase
	endtask

	// Program a consistent odd modulus with its Montgomery constants
	task automatic set_modulus(logic [29:0] n);
		logic [31:0] ni, r2;
		logic [63:0] rr;
		ni = 32'd1;
		repeat (5) ni = ni * (32'd2 - {2'b0, n} * ni);
		rr = (64'd1 << 32) % 64'(n);
		r2 = 32'((rr * rr) % 64'(n));
		if (r2 == 0) r2 = {2'b0, n};
		apb_write(REG_MODULUS, {2'b0, n});
		apb_write(REG_NEG_INV, -ni);
		apb_write(REG_R2, r2);
		apb_write(REG_R3, mont_product(r2, r2));
	endtask

	function automatic logic [31:0] rand_mont();
		logic [31:0] n2;
		n2 = {1'b0, sh_mod, 1'b0};
		return (n2 == 0) ? $urandom() : $urandom_range(0, n2 - 1);
	endfunction

	task automatic test_directed();
		logic [31:0] n;
		n = {2'b0, sh_mod};
		for (int op = 0; op <= int'(CMD_IS_ZERO); op++)
			send_op(4'(op), rand_mont(), rand_mont());
		send_op(CMD_TO_MONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(CMD_ADD, 2 * n - 1, 2 * n - 1);
		send_op(CMD_SUB, 32'd0, 2 * n - 1);
		send_op(CMD_NEG, 32'd0, 32'd0);
		send_op(CMD_INV, 32'd0, 32'd0);
		send_op(CMD_INV, 32'hFFFF_FFFF, 32'd0);
		send_op(CMD_DIV, 32'd5, n);
		send_op(CMD_EQ, 32'd3, n + 3);
		send_op(CMD_IS_ZERO, n, 32'd0);
		send_op(CMD_IS_ZERO, 32'd0, 32'd0);
		send_op(4'd11, 32'd1, 32'd2);
		send_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_random(int unsigned count);
		logic [3:0] op;
		logic [31:0] x, y;
		repeat (count) begin
			op = 4'($urandom_range(0, 10));
			if ($urandom_range(0, 15) == 0) op = 4'($urandom_range(0, 15));
			// inverse is slow, keep it rare
			if ((op == CMD_INV || op == CMD_DIV) && $urandom_range(0, 2) != 0) op = CMD_MUL;
			x = ($urandom_range(0, 9) == 0) ? $urandom() : rand_mont();
			y = ($urandom_range(0, 9) == 0) ? $urandom() : rand_mont();
			if (op == CMD_EQ && $urandom_range(0, 1)) y = x + {2'b0, sh_mod};
			send_op(op, x, y);
		end
		drain();
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_cycles = 200;
		repeat (12) send_op(CMD_ADD, rand_mont(), rand_mont());
		no_gaps = 1'b0;
		drain();
	endtask

	// Unmatched constants and even or zero modulus: same formulas, wrap mod R
	task automatic test_odd_constants();
		apb_write(REG_MODULUS, 32'h3FFF_FFFE);
		apb_write(REG_NEG_INV, $urandom());
		apb_write(REG_R2, 32'd0);
		apb_write(REG_R3, 32'hFFFF_FFFF);
		test_random(40);
		apb_write(REG_MODULUS, 32'd0);
		send_op(CMD_INV, 32'd7, 32'd0);
		send_op(CMD_DIV, 32'd3, 32'd1);
		test_random(20);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		monitor_on = 1'b1;
		@(posedge clk);
		test_directed();
		test_random(40);
		set_modulus(30'd1);
		test_random(30);
		set_modulus(30'h3FFF_FFFF);
		test_directed();
		test_random(150);
		set_modulus(30'd3);
		test_random(60);
		set_modulus(30'd1_000_003);
		test_backpressure();
		test_random(150);
		set_modulus(30'($urandom()) | 30'd1);
		test_random(100);
		test_odd_constants();
		drain();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lmma_pkg.sv
hw/rtl/lmma_if.sv
hw/rtl/lmma_div.sv
hw/rtl/lazy_montgomery_modular_alu.sv
bench/lazy_montgomery_modular_alu_tb.sv
